// ----- design/dmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// dmsd_pkg
// Widths, register map and piston state codes shared by the drive mixer.
// ----------------------------------------------------------------------------
package dmsd_pkg;

   // Fixed field widths of the request and response channels.
   localparam int DEMAND_W = 16;
   localparam int POWER_W  = 16;
   localparam int PISTON_W = 2;

   // Configuration port.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;

   localparam logic [CSR_INDEX_W-1:0] REG_STATIONARY_THRESHOLD = 1'b0;

   // Stationary threshold register, reset to 0.1 in Q1.14.
   localparam int               THRESH_W     = 15;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd1638;

   // Piston state codes.
   localparam logic [PISTON_W-1:0] PISTON_FULL     = 2'd0;
   localparam logic [PISTON_W-1:0] PISTON_EMPTY    = 2'd1;
   localparam logic [PISTON_W-1:0] PISTON_FILLING  = 2'd2;
   localparam logic [PISTON_W-1:0] PISTON_EMPTYING = 2'd3;

endpackage

// ----- design/drive_mix_with_strafe_deploy_top.sv -----
// ----------------------------------------------------------------------------
// drive_mix_with_strafe_deploy_top
// Arcade drive mixer with wheel power normalisation and strafe piston decision.
//
// Usage: each request on the req_ channel carries strafe, forward and turn
// demands in signed fixed point with FRACTION_BITS fraction bits, plus the
// current piston state. Each request yields exactly one response on the rsp_
// channel with left, right and centre wheel powers and the piston command.
// Both channels use a valid/ready handshake; a transfer happens on a rising
// clock edge with valid and ready both high.
// The pipeline runs through four mixing stages, one restoring division stage per
// quotient bit and the output register. A new request is accepted in every
// cycle in which the pipeline advances (output register empty or rsp_ready
// high), so the sustained rate is one request per clock unless rsp_ready stalls.
// When the receiver holds rsp_ready low with a response waiting, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and sets the
// stationary threshold to 0.1. The threshold is written through the csr_ port
// and is meant to change only while no request is in flight.
// ----------------------------------------------------------------------------
module drive_mix_with_strafe_deploy_top #(
   parameter int FRACTION_BITS = 14
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [dmsd_pkg::DEMAND_W-1:0]    req_strafe_demand,
   input  logic signed [dmsd_pkg::DEMAND_W-1:0]    req_forward_demand,
   input  logic signed [dmsd_pkg::DEMAND_W-1:0]    req_turn_demand,
   input  logic        [dmsd_pkg::PISTON_W-1:0]    req_piston_state,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [dmsd_pkg::POWER_W-1:0]     rsp_left_power,
   output logic signed [dmsd_pkg::POWER_W-1:0]     rsp_right_power,
   output logic signed [dmsd_pkg::POWER_W-1:0]     rsp_center_power,
   output logic                                    rsp_deploy_piston,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic        [dmsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic        [dmsd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic        [dmsd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                    csr_pready
);
   import dmsd_pkg::*;

   // Width of a saturated demand. From fifteen fraction bits on, 1.0 no longer
   // fits the demand field, so saturation never bites and the field width holds.
   localparam int SW = (FRACTION_BITS < 15) ? FRACTION_BITS + 2 : DEMAND_W;
   // Width of a mixed wheel value (signed) and of any magnitude (unsigned).
   // Unsaturated full-width demands can sum to twice the field range.
   localparam int MW = (FRACTION_BITS < 15) ? SW + 1 : SW + 2;
   // Quotient width: the normalised value never exceeds 1.0.
   localparam int QW = FRACTION_BITS + 1;
   // Common width for comparisons against 1.0 and the threshold.
   localparam int CW = (FRACTION_BITS + 2 > DEMAND_W + 1) ? FRACTION_BITS + 2 : DEMAND_W + 1;

   localparam logic        [CW-1:0] ONE_U     = {{(CW-1){1'b0}}, 1'b1} << FRACTION_BITS;
   localparam logic signed [CW-1:0] ONE_S     = ONE_U;
   localparam logic signed [CW-1:0] NEG_ONE_S = {CW{1'b0}} - ONE_U;

   // Values carried alongside the divider.
   typedef struct packed {
      logic [MW-1:0]      wheel;
      logic               neg_l;
      logic               neg_r;
      logic               div;
      logic               deploy;
      logic [POWER_W-1:0] left_raw;
      logic [POWER_W-1:0] right_raw;
      logic [POWER_W-1:0] center;
   } carry_type;

   // Clamps a demand to the range -1.0 to 1.0.
   function automatic logic signed [SW-1:0] sat_one(input logic signed [DEMAND_W-1:0] v);
      logic signed [CW-1:0] e;
      e = CW'(v);
      if (e > ONE_S) begin
         return SW'(ONE_S);
      end else if (e < NEG_ONE_S) begin
         return SW'(NEG_ONE_S);
      end else begin
         return SW'(e);
      end
   endfunction

   // Magnitude of a mixed or saturated value.
   function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
      logic signed [MW-1:0] n;
      n = -v;
      return v[MW-1] ? MW'(n) : MW'(v);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------------
   logic [THRESH_W-1:0]    thresh_ff;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_write;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write && (csr_index == REG_STATIONARY_THRESHOLD)) begin
         thresh_ff <= csr_pwdata[THRESH_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_STATIONARY_THRESHOLD: csr_prdata = CSR_DATA_W'(thresh_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flow control: every stage moves together whenever the output register is
   // empty or is being read out in this cycle.
   // ------------------------------------------------------------------------
   logic out_valid_ff;
   logic advance;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ------------------------------------------------------------------------
   // Stage 1: saturate the demands.
   // ------------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic signed [SW-1:0] s1_x_ff, s1_y_ff, s1_t_ff;
   logic [PISTON_W-1:0]  s1_piston_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff      <= sat_one(req_strafe_demand);
         s1_y_ff      <= sat_one(req_forward_demand);
         s1_t_ff      <= sat_one(req_turn_demand);
         s1_piston_ff <= req_piston_state;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: mix into left and right, take the strafe magnitude.
   // ------------------------------------------------------------------------
   logic                 s2_valid_ff;
   logic signed [MW-1:0] s2_l_ff, s2_r_ff;
   logic signed [SW-1:0] s2_x_ff;
   logic [MW-1:0]        s2_ax_ff;
   logic [PISTON_W-1:0]  s2_piston_ff;
   logic signed [MW-1:0] s2_l_in, s2_r_in;

   assign s2_l_in = -(MW'(s1_y_ff) + MW'(s1_t_ff));
   assign s2_r_in = MW'(s1_y_ff) - MW'(s1_t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_l_ff      <= s2_l_in;
         s2_r_ff      <= s2_r_in;
         s2_x_ff      <= s1_x_ff;
         s2_ax_ff     <= mag(MW'(s1_x_ff));
         s2_piston_ff <= s1_piston_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: wheel magnitudes and the larger of the two.
   // ------------------------------------------------------------------------
   logic                 s3_valid_ff;
   logic signed [MW-1:0] s3_l_ff, s3_r_ff;
   logic signed [SW-1:0] s3_x_ff;
   logic [MW-1:0]        s3_ax_ff, s3_al_ff, s3_ar_ff, s3_wheel_ff;
   logic [PISTON_W-1:0]  s3_piston_ff;
   logic [MW-1:0]        s3_al_in, s3_ar_in;

   assign s3_al_in = mag(s2_l_ff);
   assign s3_ar_in = mag(s2_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_l_ff      <= s2_l_ff;
         s3_r_ff      <= s2_r_ff;
         s3_x_ff      <= s2_x_ff;
         s3_ax_ff     <= s2_ax_ff;
         s3_al_ff     <= s3_al_in;
         s3_ar_ff     <= s3_ar_in;
         s3_wheel_ff  <= (s3_al_in > s3_ar_in) ? s3_al_in : s3_ar_in;
         s3_piston_ff <= s2_piston_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: piston decision and whether the wheels need normalising.
   // Both decisions use the magnitudes before any scaling.
   // ------------------------------------------------------------------------
   logic          s4_valid_ff;
   logic [MW-1:0] s4_al_ff, s4_ar_ff;
   carry_type     s4_carry_ff;
   carry_type     s4_carry_in;
   logic [MW-1:0] s4_biggest;
   logic          s4_stationary;

   always_comb begin
      s4_biggest    = (s3_wheel_ff > s3_ax_ff) ? s3_wheel_ff : s3_ax_ff;
      s4_stationary = CW'(s4_biggest) < CW'(thresh_ff);

      s4_carry_in.wheel = s3_wheel_ff;
      s4_carry_in.neg_l = s3_l_ff[MW-1];
      s4_carry_in.neg_r = s3_r_ff[MW-1];
      s4_carry_in.div   = CW'(s3_wheel_ff) > ONE_U;
      if (s4_stationary) begin
         // Standing still: keep the wheel down if the piston is down or going down.
         s4_carry_in.deploy = (s3_piston_ff == PISTON_FULL) ||
                              (s3_piston_ff == PISTON_FILLING);
      end else begin
         // Moving: lower the wheel when strafe is at least half the wheel demand.
         s4_carry_in.deploy = {s3_ax_ff, 1'b0} >= {1'b0, s3_wheel_ff};
      end
      s4_carry_in.left_raw  = POWER_W'(s3_l_ff);
      s4_carry_in.right_raw = POWER_W'(s3_r_ff);
      s4_carry_in.center    = POWER_W'(s3_x_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_al_ff    <= s3_al_ff;
         s4_ar_ff    <= s3_ar_ff;
         s4_carry_ff <= s4_carry_in;
      end
   end

   // ------------------------------------------------------------------------
   // Restoring division, one quotient bit per stage, for left and right in
   // parallel. It computes |value| * 1.0 / wheel; as |value| never exceeds the
   // wheel magnitude, the top quotient bit is a plain compare and each later
   // bit shifts the remainder left by one.
   // ------------------------------------------------------------------------
   logic          dv_valid_ff [QW];
   logic [MW-1:0] dv_rem_l_ff [QW];
   logic [MW-1:0] dv_rem_r_ff [QW];
   logic [QW-1:0] dv_q_l_ff   [QW];
   logic [QW-1:0] dv_q_r_ff   [QW];
   carry_type     dv_carry_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic          valid_src;
      logic [MW:0]   trial_l, trial_r, div_w, diff_l, diff_r;
      logic [QW-1:0] q_l_src, q_r_src;
      logic          ge_l, ge_r;
      carry_type     carry_src;

      if (k == 0) begin : g_first
         assign valid_src = s4_valid_ff;
         assign trial_l   = {1'b0, s4_al_ff};
         assign trial_r   = {1'b0, s4_ar_ff};
         assign q_l_src   = '0;
         assign q_r_src   = '0;
         assign carry_src = s4_carry_ff;
      end else begin : g_next
         assign valid_src = dv_valid_ff[k-1];
         assign trial_l   = {dv_rem_l_ff[k-1], 1'b0};
         assign trial_r   = {dv_rem_r_ff[k-1], 1'b0};
         assign q_l_src   = dv_q_l_ff[k-1];
         assign q_r_src   = dv_q_r_ff[k-1];
         assign carry_src = dv_carry_ff[k-1];
      end

      assign div_w  = {1'b0, carry_src.wheel};
      assign ge_l   = trial_l >= div_w;
      assign ge_r   = trial_r >= div_w;
      assign diff_l = trial_l - div_w;
      assign diff_r = trial_r - div_w;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_l_ff[k] <= ge_l ? diff_l[MW-1:0] : trial_l[MW-1:0];
            dv_rem_r_ff[k] <= ge_r ? diff_r[MW-1:0] : trial_r[MW-1:0];
            dv_q_l_ff[k]   <= {q_l_src[QW-2:0], ge_l};
            dv_q_r_ff[k]   <= {q_r_src[QW-2:0], ge_r};
            dv_carry_ff[k] <= carry_src;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register: restore the signs of the quotients, or pass the mixed
   // values through when no normalising was needed.
   // ------------------------------------------------------------------------
   carry_type                 last_carry;
   logic signed [QW:0]        q_l_pos, q_r_pos, q_l_signed, q_r_signed;
   logic signed [POWER_W-1:0] left_in, right_in;
   logic signed [POWER_W-1:0] out_left_ff, out_right_ff, out_center_ff;
   logic                      out_deploy_ff;

   always_comb begin
      last_carry = dv_carry_ff[QW-1];
      q_l_pos    = {1'b0, dv_q_l_ff[QW-1]};
      q_r_pos    = {1'b0, dv_q_r_ff[QW-1]};
      q_l_signed = last_carry.neg_l ? -q_l_pos : q_l_pos;
      q_r_signed = last_carry.neg_r ? -q_r_pos : q_r_pos;
      if (last_carry.div) begin
         left_in  = POWER_W'(q_l_signed);
         right_in = POWER_W'(q_r_signed);
      end else begin
         left_in  = last_carry.left_raw;
         right_in = last_carry.right_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_left_ff   <= left_in;
         out_right_ff  <= right_in;
         out_center_ff <= last_carry.center;
         out_deploy_ff <= last_carry.deploy;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_left_power    = out_left_ff;
   assign rsp_right_power   = out_right_ff;
   assign rsp_center_power  = out_center_ff;
   assign rsp_deploy_piston = out_deploy_ff;

`ifndef SYNTHESIS
   // A normalised wheel power never exceeds 1.0 in magnitude.
   assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[QW-1] && dv_carry_ff[QW-1].div |->
         (CW'(dv_q_l_ff[QW-1]) <= ONE_U) && (CW'(dv_q_r_ff[QW-1]) <= ONE_U))
      else $error("normalised wheel quotient above 1.0");

   // The division leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[QW-1] && dv_carry_ff[QW-1].div |->
         (dv_rem_l_ff[QW-1] < dv_carry_ff[QW-1].wheel) &&
         (dv_rem_r_ff[QW-1] < dv_carry_ff[QW-1].wheel))
      else $error("divider remainder not below the wheel magnitude");

   // While the receiver stalls, the last divider stage keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> out_valid_ff && $stable(dv_valid_ff[QW-1]) &&
         $stable(dv_q_l_ff[QW-1]) && $stable(dv_q_r_ff[QW-1]))
      else $error("pipeline moved during a stall");
`endif

endmodule
